// ----- rtl/core/ilt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ilt_pkg;

  // width of every offset or count field of a result item
  localparam int FIELD_W = 16;

  // default width of the internal stream offsets
  localparam int OFFSET_BITS_DEF = 16;

  // character codes
  localparam logic [7:0] CHR_EQUALS    = 8'h3D;
  localparam logic [7:0] CHR_HASH      = 8'h23;
  localparam logic [7:0] CHR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_LF        = 8'h0A;
  localparam logic [7:0] CHR_CR        = 8'h0D;
  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] CHR_TAB       = 8'h09;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_START   = 3'd1,
    MODE_LINE    = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_ESC     = 3'd4,
    MODE_ESC_LF  = 3'd5,
    MODE_ESC_CR  = 3'd6
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] line_offset;
    logic [FIELD_W-1:0] line_bytes;
    logic               has_equals;
    logic [FIELD_W-1:0] equals_offset;
    logic               is_section;
    logic               bracket_closed;
    logic [FIELD_W-1:0] bracket_offset;
    logic               overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ilt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ilt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ilt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ilt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_offset;
  logic [15:0] line_bytes;
  logic        has_equals;
  logic [15:0] equals_offset;
  logic        is_section;
  logic        bracket_closed;
  logic [15:0] bracket_offset;
  logic        overflow;

  modport source (
    output valid, output line_offset, output line_bytes, output has_equals,
    output equals_offset, output is_section, output bracket_closed,
    output bracket_offset, output overflow, input ready
  );
  modport sink (
    input valid, input line_offset, input line_bytes, input has_equals,
    input equals_offset, input is_section, input bracket_closed,
    input bracket_offset, input overflow, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ilt_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilt_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ilt_in_if.sink             in_stream,
  output ilt_pkg::item_t     item,
  output logic               item_valid,
  input  wire logic          take
);
  import ilt_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  ready;

  // the register frees up in the same cycle that the scanner takes it
  assign ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (ready) begin
      valid_nxt = in_stream.valid;
      if (in_stream.valid) begin
        item_nxt.text_byte   = in_stream.text_byte;
        item_nxt.end_of_text = in_stream.end_of_text;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign in_stream.ready = ready;
  assign item            = item_r;
  assign item_valid      = valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/ilt_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilt_scan #(
  parameter int OFFSET_BITS = ilt_pkg::OFFSET_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ilt_pkg::item_t item,
  input  wire logic          item_valid,
  output logic               take,
  ilt_out_if.source          out_stream
);
  import ilt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
  localparam logic [OFFSET_BITS-1:0] POS_ZERO = '0;
  localparam logic [OFFSET_BITS-1:0] POS_ONE  = OFFSET_BITS'(1);

  // scan state
  scan_mode_t             mode_r,  mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r,   pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   eq_seen_r, eq_seen_nxt;
  logic [OFFSET_BITS-1:0] eq_at_r, eq_at_nxt;
  logic                   br_seen_r, br_seen_nxt;
  logic [OFFSET_BITS-1:0] br_at_r, br_at_nxt;
  logic                   opens_r, opens_nxt;
  logic                   sat_r,   sat_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  logic [7:0]             b;
  logic                   last, is_nl, at_max;
  logic                   do_line, note, emit_nl, flush, emit, emit_sat;
  logic [OFFSET_BITS-1:0] end_pos, span;

  // zero-extend or truncate an offset to the 16-bit field
  function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, v};
    return wide[FIELD_W-1:0];
  endfunction

  assign take = item_valid && (!out_valid_r || out_stream.ready);

  always_comb begin
    b       = item.text_byte;
    last    = item.end_of_text;
    is_nl   = (b == CHR_LF) || (b == CHR_CR);
    at_max  = (pos_r == POS_MAX);

    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    eq_seen_nxt = eq_seen_r;
    eq_at_nxt   = eq_at_r;
    br_seen_nxt = br_seen_r;
    br_at_nxt   = br_at_r;
    opens_nxt   = opens_r;
    sat_nxt     = sat_r;
    do_line     = 1'b0;
    note        = 1'b0;
    emit_nl     = 1'b0;

    unique case (mode_r)
      MODE_LINE: begin
        do_line = 1'b1;
      end
      MODE_COMMENT: begin
        if (is_nl) begin
          mode_nxt = MODE_START;
        end
      end
      MODE_ESC: begin
        note = 1'b1;
        if (b == CHR_LF) begin
          mode_nxt = MODE_ESC_LF;
        end else if (b == CHR_CR) begin
          mode_nxt = MODE_ESC_CR;
        end else begin
          mode_nxt = MODE_LINE;
        end
      end
      MODE_ESC_LF: begin
        if (b == CHR_CR) begin
          mode_nxt = MODE_LINE;
        end else begin
          do_line = 1'b1;
        end
      end
      MODE_ESC_CR: begin
        if (b == CHR_LF) begin
          mode_nxt = MODE_LINE;
        end else begin
          do_line = 1'b1;
        end
      end
      default: begin
        // whitespace skip, start after a comment, and unused codes
        if (is_nl || (mode_r != MODE_START && (b == CHR_SPACE || b == CHR_TAB))) begin
          mode_nxt = mode_r;
        end else if (b == CHR_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          start_nxt   = pos_r;
          eq_seen_nxt = 1'b0;
          eq_at_nxt   = POS_ZERO;
          br_seen_nxt = 1'b0;
          br_at_nxt   = POS_ZERO;
          opens_nxt   = (b == CHR_LBRACKET);
          do_line     = 1'b1;
        end
      end
    endcase

    if (do_line) begin
      if (is_nl) begin
        emit_nl  = 1'b1;
        mode_nxt = MODE_SKIP;
      end else begin
        note = 1'b1;
        if (b == CHR_EQUALS && !eq_seen_nxt) begin
          eq_seen_nxt = 1'b1;
          eq_at_nxt   = pos_r;
        end
        mode_nxt = (b == CHR_BACKSLASH) ? MODE_ESC : MODE_LINE;
      end
    end

    if (note && b == CHR_RBRACKET && !br_seen_nxt) begin
      br_seen_nxt = 1'b1;
      br_at_nxt   = pos_r;
    end

    // an open line is closed by the last byte of the stream
    flush = last && !emit_nl &&
            (mode_nxt == MODE_LINE || mode_nxt == MODE_ESC ||
             mode_nxt == MODE_ESC_LF || mode_nxt == MODE_ESC_CR);
    emit     = emit_nl || flush;
    emit_sat = sat_r || (flush && at_max);
    if (emit_nl) begin
      end_pos = pos_r;
    end else if (at_max) begin
      end_pos = POS_MAX;
    end else begin
      end_pos = pos_r + POS_ONE;
    end
    span = end_pos - start_nxt;

    res_nxt.line_offset    = to_field(start_nxt);
    res_nxt.line_bytes     = to_field(span);
    res_nxt.has_equals     = eq_seen_nxt;
    res_nxt.equals_offset  = eq_seen_nxt ? to_field(eq_at_nxt) : '0;
    res_nxt.is_section     = opens_nxt;
    res_nxt.bracket_closed = br_seen_nxt;
    res_nxt.bracket_offset = br_seen_nxt ? to_field(br_at_nxt) : '0;
    res_nxt.overflow       = emit_sat;

    if (last) begin
      // back to the reset state for a fresh stream
      mode_nxt    = MODE_SKIP;
      pos_nxt     = POS_ZERO;
      start_nxt   = POS_ZERO;
      eq_seen_nxt = 1'b0;
      eq_at_nxt   = POS_ZERO;
      br_seen_nxt = 1'b0;
      br_at_nxt   = POS_ZERO;
      opens_nxt   = 1'b0;
      sat_nxt     = 1'b0;
    end else if (at_max) begin
      sat_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_ONE;
    end

    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_stream.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SKIP;
      pos_r       <= POS_ZERO;
      start_r     <= POS_ZERO;
      eq_seen_r   <= 1'b0;
      eq_at_r     <= POS_ZERO;
      br_seen_r   <= 1'b0;
      br_at_r     <= POS_ZERO;
      opens_r     <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r    <= mode_nxt;
        pos_r     <= pos_nxt;
        start_r   <= start_nxt;
        eq_seen_r <= eq_seen_nxt;
        eq_at_r   <= eq_at_nxt;
        br_seen_r <= br_seen_nxt;
        br_at_r   <= br_at_nxt;
        opens_r   <= opens_nxt;
        sat_r     <= sat_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.line_offset    = res_r.line_offset;
  assign out_stream.line_bytes     = res_r.line_bytes;
  assign out_stream.has_equals     = res_r.has_equals;
  assign out_stream.equals_offset  = res_r.equals_offset;
  assign out_stream.is_section     = res_r.is_section;
  assign out_stream.bracket_closed = res_r.bracket_closed;
  assign out_stream.bracket_offset = res_r.bracket_offset;
  assign out_stream.overflow       = res_r.overflow;

  // a line without saturation always holds at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.overflow |-> res_r.line_bytes != '0)
    else $error("empty line without overflow");

  // no equals sign means a zero equals offset
  a_eq_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.has_equals |-> res_r.equals_offset == '0)
    else $error("equals offset set without equals sign");

  // end of stream returns the scanner to its reset state
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.end_of_text |=> pos_r == POS_ZERO && mode_r == MODE_SKIP && !sat_r)
    else $error("scanner not cleared after end of stream");

  // the stream position never moves backwards within a stream
  a_pos_mono: assert property (@(posedge clk) disable iff (!rst_n)
    take && !item.end_of_text |=> pos_r >= $past(pos_r))
    else $error("stream position went backwards");

endmodule

`default_nettype wire

// ----- rtl/core/ini_line_tokenizer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel      dir  handshake    payload
// in_stream    in   valid/ready  text_byte[7:0], end_of_text
// out_stream   out  valid/ready  line_offset, line_bytes, has_equals, equals_offset,
//                                is_section, bracket_closed, bracket_offset, overflow
//
// one byte item per cycle sustained while out_stream does not stall; a taken byte passes
// through the input register, then the scan logic into the result register
// the scan state is one small mode register and a few offset registers updated
// in a single pass per byte
// rst_n is synchronous, active low, and clears the scan state and both valids
// a stalled result holds the result register; the input register takes a byte only if
// it is empty, and accepts again as soon as the result moves on

module ini_line_tokenizer_top #(
  parameter int OFFSET_BITS = ilt_pkg::OFFSET_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ilt_in_if.sink    in_stream,
  ilt_out_if.source out_stream
);
  import ilt_pkg::*;

  // byte held between the input register and the scanner
  item_t item;
  logic  item_valid;
  logic  take;

  // input register: parts the upstream handshake from the scanner
  ilt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .item       (item),
    .item_valid (item_valid),
    .take       (take)
  );

  // line scanner with its result register
  ilt_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .take       (take),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire
